// File: sv/double_ended_queue_defines.svh
// Assertion macros shared by the deque RTL.
`ifndef DOUBLE_ENDED_QUEUE_DEFINES_SVH
`define DOUBLE_ENDED_QUEUE_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define DEQ_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("deque check failed");

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define DEQ_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("deque check failed");

`endif

// File: sv/deq_pkg.sv
// Types, constants and helpers for the double-ended queue.
package deq_pkg;

	localparam int DEPTH      = 1024;
	localparam int DATA_WIDTH = 32;
	localparam int WORD_W     = 32;
	localparam int ADDR_W     = $clog2(DEPTH);
	localparam int CNT_W      = $clog2(DEPTH + 1);

	typedef logic [ADDR_W-1:0]     addr_t;
	typedef logic [CNT_W-1:0]      cnt_t;
	typedef logic [DATA_WIDTH-1:0] data_t;

	typedef enum logic [2:0] {
		OP_PUSH_FRONT = 3'd0,
		OP_PUSH_BACK  = 3'd1,
		OP_POP_FRONT  = 3'd2,
		OP_POP_BACK   = 3'd3,
		OP_PEEK_FRONT = 3'd4,
		OP_PEEK_BACK  = 3'd5
	} op_t;

	typedef struct packed {
		logic  we;
		logic  re;
		addr_t addr;
		data_t wdata;
	} mem_req_t;

	typedef struct packed {
		logic read_valid;
		logic push_dropped;
		cnt_t entry_count;
		logic is_empty;
	} res_t;

	function automatic addr_t wrap_inc(input addr_t p);
		return (p == addr_t'(DEPTH - 1)) ? '0 : p + addr_t'(1);
	endfunction

	function automatic addr_t wrap_dec(input addr_t p);
		return (p == '0) ? addr_t'(DEPTH - 1) : p - addr_t'(1);
	endfunction

	// Narrow or sign extend a port word to the stored width.
	function automatic data_t to_data(input logic signed [WORD_W-1:0] w);
		return DATA_WIDTH'(w);
	endfunction

	// Sign extend or narrow a stored word to the port width.
	function automatic logic [WORD_W-1:0] to_word(input logic signed [DATA_WIDTH-1:0] d);
		return WORD_W'(d);
	endfunction

endpackage

// File: sv/deq_ram.sv
// Single-port synchronous RAM with registered read data.
module deq_ram #(
	parameter int DEPTH_P = 1024,
	parameter int WIDTH_P = 32
) (
	input  logic                       clk,
	input  logic                       we,
	input  logic                       re,
	input  logic [$clog2(DEPTH_P)-1:0] addr,
	input  logic [WIDTH_P-1:0]         wdata,
	output logic [WIDTH_P-1:0]         rdata
);

	logic [WIDTH_P-1:0] mem_q [DEPTH_P];
	logic [WIDTH_P-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[addr];
		end
	end

	assign rdata = rdata_q;

endmodule

// File: sv/deq_ctrl.sv
// Pointer and count control: decodes an item into a RAM access and result flags.
module deq_ctrl import deq_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    accept,
	input  logic [2:0]              func,
	input  logic signed [WORD_W-1:0] push_value,
	output mem_req_t                mem_req,
	output res_t                    res
);

	addr_t front_q, back_q;
	cnt_t  count_q;
	addr_t front_d, back_d;
	cnt_t  count_d;
	logic  full, empty;
	logic  rd_hit, dropped;

	assign full  = (count_q == cnt_t'(DEPTH));
	assign empty = (count_q == '0);

	always_comb begin
		front_d       = front_q;
		back_d        = back_q;
		count_d       = count_q;
		rd_hit        = 1'b0;
		dropped       = 1'b0;
		mem_req.we    = 1'b0;
		mem_req.re    = 1'b0;
		mem_req.addr  = front_q;
		mem_req.wdata = to_data(push_value);
		unique case (op_t'(func))
			OP_PUSH_FRONT: begin
				if (full) begin
					dropped = 1'b1;
				end else begin
					front_d      = wrap_dec(front_q);
					mem_req.we   = 1'b1;
					mem_req.addr = front_d;
					count_d      = count_q + cnt_t'(1);
				end
			end
			OP_PUSH_BACK: begin
				if (full) begin
					dropped = 1'b1;
				end else begin
					back_d       = wrap_inc(back_q);
					mem_req.we   = 1'b1;
					mem_req.addr = back_q;
					count_d      = count_q + cnt_t'(1);
				end
			end
			OP_POP_FRONT: begin
				if (!empty) begin
					rd_hit       = 1'b1;
					mem_req.re   = 1'b1;
					mem_req.addr = front_q;
					front_d      = wrap_inc(front_q);
					count_d      = count_q - cnt_t'(1);
				end
			end
			OP_POP_BACK: begin
				if (!empty) begin
					rd_hit       = 1'b1;
					back_d       = wrap_dec(back_q);
					mem_req.re   = 1'b1;
					mem_req.addr = back_d;
					count_d      = count_q - cnt_t'(1);
				end
			end
			OP_PEEK_FRONT: begin
				if (!empty) begin
					rd_hit       = 1'b1;
					mem_req.re   = 1'b1;
					mem_req.addr = front_q;
				end
			end
			OP_PEEK_BACK: begin
				if (!empty) begin
					rd_hit       = 1'b1;
					mem_req.re   = 1'b1;
					mem_req.addr = wrap_dec(back_q);
				end
			end
			default: begin
				// unused codes: report count only
			end
		endcase
		// gate RAM strobes with the handshake
		mem_req.we = mem_req.we & accept;
		mem_req.re = mem_req.re & accept;
	end

	assign res.read_valid   = rd_hit;
	assign res.push_dropped = dropped;
	assign res.entry_count  = count_d;
	assign res.is_empty     = (count_d == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_q <= '0;
			back_q  <= '0;
			count_q <= '0;
		end else if (accept) begin
			front_q <= front_d;
			back_q  <= back_d;
			count_q <= count_d;
		end
	end

endmodule

// File: sv/double_ended_queue.sv
// Top level of the double-ended queue: control, entry RAM and result register.
//
//  channel | valid     | ready     | payload
//  --------+-----------+-----------+--------------------------------------------------
//  input   | in_valid  | in_ready  | func, push_value
//  output  | out_valid | out_ready | read_value, read_valid, push_dropped,
//          |           |           | entry_count, is_empty
//
// One item per cycle sustained while out_ready is high; each item's result appears in the cycle after it
// is accepted, as the entry RAM read data is registered.
// Pointers and count live in flops and update at accept; the RAM takes one
// write (push) or one read (pop/peek) at most per item, so a push is visible to the
// very next item without forwarding.
// Reset clears pointers, count and the result valid; RAM contents stay
// undefined, as only pushed entries are ever read.
// An output stall holds the result register and the RAM read data; a new item
// is taken in the same cycle the held result leaves.
`include "double_ended_queue_defines.svh"

module double_ended_queue import deq_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic [2:0]               func,
	input  logic signed [WORD_W-1:0] push_value,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic signed [WORD_W-1:0] read_value,
	output logic                     read_valid,
	output logic                     push_dropped,
	output logic [CNT_W-1:0]         entry_count,
	output logic                     is_empty
);

	logic     in_accept;
	mem_req_t mem_req;
	res_t     res;
	res_t     res_s1;
	logic     valid_s1;
	data_t    rdata;

	// Take an item when the result slot is empty or draining this cycle.
	assign in_ready  = !valid_s1 || out_ready;
	assign in_accept = in_valid && in_ready;

	deq_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (in_accept),
		.func       (func),
		.push_value (push_value),
		.mem_req    (mem_req),
		.res        (res)
	);

	deq_ram #(
		.DEPTH_P (DEPTH),
		.WIDTH_P (DATA_WIDTH)
	) u_ram (
		.clk   (clk),
		.we    (mem_req.we),
		.re    (mem_req.re),
		.addr  (mem_req.addr),
		.wdata (mem_req.wdata),
		.rdata (rdata)
	);

	// Result stage: valid flag under reset, flags held until the next accept.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			res_s1 <= res;
		end
	end

	// The RAM read register only moves on an accepted read, so it holds with res_s1.
	assign out_valid    = valid_s1;
	assign read_valid   = res_s1.read_valid;
	assign read_value   = res_s1.read_valid ? to_word(rdata) : '0;
	assign push_dropped = res_s1.push_dropped;
	assign entry_count  = res_s1.entry_count;
	assign is_empty     = res_s1.is_empty;

	`DEQ_ASSERT_NEXT(a_accept_gives_result, in_accept, valid_s1)
	`DEQ_ASSERT_IMPL(a_flags_exclusive, valid_s1, !(res_s1.read_valid && res_s1.push_dropped))
	`DEQ_ASSERT_IMPL(a_drop_means_full, valid_s1 && res_s1.push_dropped, res_s1.entry_count == CNT_W'(DEPTH))
	`DEQ_ASSERT_IMPL(a_empty_matches_count, valid_s1, res_s1.is_empty == (res_s1.entry_count == '0))

endmodule
